// ----- hdl/jsrd_pkg.sv -----
// ============================================================================
// jsrd_pkg
// shared types, codes and the report decode function for the serial report
// deframer
// ============================================================================
package jsrd_pkg;

    localparam logic [7:0] SYNC_BYTE    = 8'h2b;
    localparam logic [7:0] ID_BYTE_MAX  = 8'd3;
    localparam int         PAYLOAD_USED = 7;
    localparam int         PIDX_W       = $clog2(PAYLOAD_USED);

    typedef enum logic [1:0] {
        ID_NONE     = 2'd0,
        ID_JOYSTICK = 2'd1,
        ID_STATUS   = 2'd2,
        ID_WHEEL    = 2'd3
    } frame_id_t;

    typedef logic [PAYLOAD_USED-1:0][7:0] payload_t;

    typedef struct packed {
        logic [11:0]        buttons;
        logic signed [1:0]  hat_y;
        logic signed [1:0]  hat_x;
        logic [7:0]         third_axis;
        logic signed [15:0] second_axis;
        logic signed [15:0] main_axis;
        logic               is_wheel;
    } report_t;

    // hat direction, clockwise from up, upper half centered
    localparam logic [1:0] HAT_X [16] = '{
        2'b00, 2'b01, 2'b01, 2'b01, 2'b00, 2'b11, 2'b11, 2'b11,
        2'b00, 2'b00, 2'b00, 2'b00, 2'b00, 2'b00, 2'b00, 2'b00
    };
    localparam logic [1:0] HAT_Y [16] = '{
        2'b11, 2'b11, 2'b00, 2'b01, 2'b01, 2'b01, 2'b00, 2'b11,
        2'b00, 2'b00, 2'b00, 2'b00, 2'b00, 2'b00, 2'b00, 2'b00
    };

    function automatic report_t decode_report(payload_t p, logic wheel);
        report_t    r;
        logic [3:0] hat;
        hat          = p[6][7:4];
        r.is_wheel   = wheel;
        r.main_axis  = {p[1], p[0]};
        if (wheel) begin
            r.second_axis = {8'h00, 8'hff - p[2]};
            r.third_axis  = 8'hff - p[3];
        end else begin
            r.second_axis = {p[3], p[2]};
            r.third_axis  = 8'hff - p[4];
        end
        r.hat_x   = HAT_X[hat];
        r.hat_y   = HAT_Y[hat];
        r.buttons = {p[6][3:0], p[5]};
        return r;
    endfunction

endpackage

// ----- hdl/jsrd_parser.sv -----
// ============================================================================
// jsrd_parser
// frame state, payload bytes and report decode for one received byte
// ============================================================================
module jsrd_parser
    import jsrd_pkg::*;
#(
    parameter int MAX_PAYLOAD = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       byte_valid,
    input  logic [7:0] rx_byte,
    output logic       res_valid,
    output report_t    res
);

    localparam int         LEN_W        = $clog2(MAX_PAYLOAD + 1);
    localparam logic [7:0] LEN_BYTE_MAX = 8'(MAX_PAYLOAD);

    logic             in_frame_reg, in_frame_next;
    frame_id_t        id_reg, id_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] idx_reg, idx_next;
    payload_t         payload_reg, payload_next;

    always_comb begin
        in_frame_next = in_frame_reg;
        id_next       = id_reg;
        len_next      = len_reg;
        idx_next      = idx_reg;
        payload_next  = payload_reg;
        res_valid     = 1'b0;
        if (byte_valid) begin
            priority if (!in_frame_reg) begin
                if (rx_byte == SYNC_BYTE) begin
                    in_frame_next = 1'b1;
                end
            end else if (id_reg == ID_NONE) begin
                if (rx_byte > ID_BYTE_MAX) begin
                    in_frame_next = 1'b0;
                end else begin
                    id_next = frame_id_t'(rx_byte[1:0]);
                end
            end else if (len_reg == '0) begin
                if (rx_byte > LEN_BYTE_MAX) begin
                    in_frame_next = 1'b0;
                    id_next       = ID_NONE;
                end else begin
                    len_next = rx_byte[LEN_W-1:0];
                end
            end else if (idx_reg < len_reg) begin
                if (idx_reg < LEN_W'(PAYLOAD_USED)) begin
                    payload_next[idx_reg[PIDX_W-1:0]] = rx_byte;
                end
                idx_next = idx_reg + 1'b1;
            end else begin
                // checksum byte ends the frame
                res_valid     = (id_reg == ID_JOYSTICK) || (id_reg == ID_WHEEL);
                in_frame_next = 1'b0;
                id_next       = ID_NONE;
                len_next      = '0;
                idx_next      = '0;
            end
        end
    end

    assign res = decode_report(payload_reg, id_reg == ID_WHEEL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            id_reg       <= ID_NONE;
            len_reg      <= '0;
            idx_reg      <= '0;
            payload_reg  <= '0;
        end else begin
            in_frame_reg <= in_frame_next;
            id_reg       <= id_next;
            len_reg      <= len_next;
            idx_reg      <= idx_next;
            payload_reg  <= payload_next;
        end
    end

endmodule

// ----- hdl/jsrd_out_buf.sv -----
// ============================================================================
// jsrd_out_buf
// report output register with a skid entry
// ============================================================================
module jsrd_out_buf
    import jsrd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  report_t push_data,
    output logic    full,
    output logic    out_valid,
    input  logic    out_ready,
    output report_t out_data
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    report_t main_reg, main_next;
    report_t skid_reg, skid_next;
    logic    pop;

    assign pop = main_valid_reg && out_ready;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        priority if (skid_valid_reg) begin
            if (pop) begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push && (!main_valid_reg || pop)) begin
            main_next       = push_data;
            main_valid_next = 1'b1;
        end else if (push) begin
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end else if (pop) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule

// ----- hdl/joystick_serial_report_deframer.sv -----
// ============================================================================
// joystick_serial_report_deframer
// deframes serial joystick and wheel reports into decoded report requests
// ============================================================================
// Takes one received serial byte per clock. A frame is sync byte 0x2b, id,
// length, payload and a checksum byte that is not checked; joystick (id 1)
// and wheel (id 3) frames give one decoded report, pushed into the output
// buffer when their checksum byte is taken; other frames give nothing.
// Reports pass through a two-entry output buffer (output register plus skid
// entry); the input only stalls while both entries are held by a stalled
// output, so with the output side ready the block takes a byte every cycle.
// MAX_PAYLOAD sets the longest payload accepted; longer frames are dropped.
module joystick_serial_report_deframer
    import jsrd_pkg::*;
#(
    parameter int MAX_PAYLOAD = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // main_axis, second_axis, third_axis,
                                        // hat_x, hat_y, buttons
    output logic [0:0]  m_axis_tuser    // is_wheel
);

    logic    byte_accept;
    logic    res_valid;
    report_t res;
    logic    buf_full;
    report_t out_rep;

    assign s_axis_tready = !buf_full;
    assign byte_accept   = s_axis_tvalid && s_axis_tready;

    jsrd_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (byte_accept),
        .rx_byte    (s_axis_tdata),
        .res_valid  (res_valid),
        .res        (res)
    );

    jsrd_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .full      (buf_full),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_rep)
    );

    assign m_axis_tdata = {out_rep.buttons, out_rep.hat_y, out_rep.hat_x,
                           out_rep.third_axis, out_rep.second_axis, out_rep.main_axis};
    assign m_axis_tuser = out_rep.is_wheel;

endmodule
